[rtl/qts_pkg.sv]
// ----------------------------------------------------------------------------
// qts_pkg
// Shared types and codes for the quadrature time setter: edit target codes
// and the packed time and result records passed between modules.
// ----------------------------------------------------------------------------
package qts_pkg;

    // edit target codes as written through the configuration port
    typedef enum logic [2:0] {
        TGT_NONE         = 3'd0,
        TGT_DAY          = 3'd1,
        TGT_HOUR         = 3'd2,
        TGT_MINUTE       = 3'd3,
        TGT_ALARM_HOUR   = 3'd4,
        TGT_ALARM_MINUTE = 3'd5
    } qts_target_t;

    localparam logic [2:0] DAY_LAST    = 3'd6;
    localparam logic [1:0] HOUR_TENS_LAST = 2'd2;
    localparam logic [3:0] HOUR_ONES_LAST = 4'd3;
    localparam logic [2:0] MIN_TENS_LAST  = 3'd5;
    localparam logic [3:0] ONES_LAST      = 4'd9;

    // one bcd hour pair
    typedef struct packed {
        logic [1:0] tens;
        logic [3:0] ones;
    } qts_hour_t;

    // one bcd minute pair
    typedef struct packed {
        logic [2:0] tens;
        logic [3:0] ones;
    } qts_minute_t;

    // all settable values
    typedef struct packed {
        logic [2:0]  day;
        qts_hour_t   hour;
        qts_minute_t minute;
        qts_hour_t   alarm_hour;
        qts_minute_t alarm_minute;
    } qts_time_t;

    // one result beat
    typedef struct packed {
        logic      moved;
        logic      turn_up;
        qts_time_t values;
    } qts_result_t;

endpackage

[rtl/qts_step.sv]
// ----------------------------------------------------------------------------
// qts_step
// Next-state logic for one pin sample: quadrature decode, direction, and
// the wrapped up/down step of the selected time value.
// ----------------------------------------------------------------------------
module qts_step (
    input  logic                pin_a,
    input  logic                pin_b,
    input  logic [1:0]          quad_pos,
    input  logic                dir,
    input  logic [2:0]          target,
    input  qts_pkg::qts_time_t  values,
    output logic [1:0]          quad_pos_next,
    output logic                dir_next,
    output logic                moved,
    output qts_pkg::qts_time_t  values_next
);
    import qts_pkg::*;

    // bcd hour step, 23 wraps to 00 and back
    function automatic qts_hour_t step_hour(input qts_hour_t h, input logic up);
        qts_hour_t r;
        r = h;
        if (up)
        begin
            if (h.tens >= HOUR_TENS_LAST && h.ones >= HOUR_ONES_LAST)
            begin
                r.tens = 2'd0;
                r.ones = 4'd0;
            end
            else if (h.ones >= ONES_LAST)
            begin
                r.tens = h.tens + 2'd1;
                r.ones = 4'd0;
            end
            else
            begin
                r.ones = h.ones + 4'd1;
            end
        end
        else
        begin
            if (h.ones == 4'd0)
            begin
                if (h.tens == 2'd0)
                begin
                    r.tens = HOUR_TENS_LAST;
                    r.ones = HOUR_ONES_LAST;
                end
                else
                begin
                    r.tens = h.tens - 2'd1;
                    r.ones = ONES_LAST;
                end
            end
            else
            begin
                r.ones = h.ones - 4'd1;
            end
        end
        return r;
    endfunction

    // bcd minute step, 59 wraps to 00 and back
    function automatic qts_minute_t step_minute(input qts_minute_t m, input logic up);
        qts_minute_t r;
        r = m;
        if (up)
        begin
            if (m.ones >= ONES_LAST)
            begin
                r.ones = 4'd0;
                r.tens = (m.tens >= MIN_TENS_LAST) ? 3'd0 : m.tens + 3'd1;
            end
            else
            begin
                r.ones = m.ones + 4'd1;
            end
        end
        else
        begin
            if (m.ones == 4'd0)
            begin
                r.tens = (m.tens == 3'd0) ? MIN_TENS_LAST : m.tens - 3'd1;
                r.ones = ONES_LAST;
            end
            else
            begin
                r.ones = m.ones - 4'd1;
            end
        end
        return r;
    endfunction

    // quadrature decode, the first matching transition wins
    always_comb
    begin
        quad_pos_next = quad_pos;
        dir_next      = dir;
        unique case (quad_pos)
            2'd0:
            begin
                priority if (pin_a)
                begin
                    quad_pos_next = 2'd1;
                    dir_next      = 1'b1;
                end
                else if (pin_b)
                begin
                    quad_pos_next = 2'd2;
                    dir_next      = 1'b0;
                end
                else
                begin
                    quad_pos_next = quad_pos;
                    dir_next      = dir;
                end
            end
            2'd1:
            begin
                priority if (!pin_a)
                begin
                    quad_pos_next = 2'd0;
                    dir_next      = 1'b0;
                end
                else if (pin_b)
                begin
                    quad_pos_next = 2'd3;
                    dir_next      = 1'b1;
                end
                else
                begin
                    quad_pos_next = quad_pos;
                    dir_next      = dir;
                end
            end
            2'd2:
            begin
                priority if (pin_a)
                begin
                    quad_pos_next = 2'd3;
                    dir_next      = 1'b0;
                end
                else if (!pin_b)
                begin
                    quad_pos_next = 2'd0;
                    dir_next      = 1'b1;
                end
                else
                begin
                    quad_pos_next = quad_pos;
                    dir_next      = dir;
                end
            end
            default:
            begin
                priority if (!pin_a)
                begin
                    quad_pos_next = 2'd2;
                    dir_next      = 1'b1;
                end
                else if (!pin_b)
                begin
                    quad_pos_next = 2'd1;
                    dir_next      = 1'b0;
                end
                else
                begin
                    quad_pos_next = quad_pos;
                    dir_next      = dir;
                end
            end
        endcase
    end

    assign moved = (quad_pos_next != quad_pos);

    // step the selected value when the encoder moved
    always_comb
    begin
        values_next = values;
        if (moved)
        begin
            unique case (target)
                TGT_DAY:
                begin
                    if (dir_next)
                        values_next.day = (values.day >= DAY_LAST) ? 3'd0 : values.day + 3'd1;
                    else
                        values_next.day = (values.day == 3'd0) ? DAY_LAST : values.day - 3'd1;
                end
                TGT_HOUR:         values_next.hour = step_hour(values.hour, dir_next);
                TGT_MINUTE:       values_next.minute = step_minute(values.minute, dir_next);
                TGT_ALARM_HOUR:   values_next.alarm_hour = step_hour(values.alarm_hour, dir_next);
                TGT_ALARM_MINUTE:
                    values_next.alarm_minute = step_minute(values.alarm_minute, dir_next);
                default:          values_next = values;
            endcase
        end
    end

endmodule

[rtl/quadrature_time_setter.sv]
// Results are registered, via the skid entry while the output is held.
// Throughput: one sample per cycle while sample_ready is high; decode and
// digit step are short combinational logic between the state and result registers.
// A two-entry output (result register plus skid) keeps samples flowing while
// one result waits; sample_ready drops only when both entries are full.
// Reset (rst_n low, async): position 0, clockwise, all values 00, target none.
// ----------------------------------------------------------------------------
// quadrature_time_setter
// Rotary encoder front end that steps day, clock time or alarm time in BCD.
// ----------------------------------------------------------------------------
module quadrature_time_setter (
    input  logic       clk,
    input  logic       rst_n,
    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] edit_target,
    // sample channel
    input  logic       sample_valid,
    output logic       sample_ready,
    input  logic       pin_a,
    input  logic       pin_b,
    // result channel
    output logic       result_valid,
    input  logic       result_ready,
    output logic       moved,
    output logic       turn_up,
    output logic [2:0] day_value,
    output logic [1:0] hour_tens,
    output logic [3:0] hour_ones,
    output logic [2:0] minute_tens,
    output logic [3:0] minute_ones,
    output logic [1:0] alarm_hour_tens,
    output logic [3:0] alarm_hour_ones,
    output logic [2:0] alarm_minute_tens,
    output logic [3:0] alarm_minute_ones
);
    import qts_pkg::*;

    logic [2:0]  target_reg;
    logic [1:0]  quad_pos_reg;
    logic [1:0]  quad_pos_next;
    logic        dir_reg;
    logic        dir_next;
    logic        moved_next;
    qts_time_t   values_reg;
    qts_time_t   values_next;
    qts_result_t result_next;
    qts_result_t out_reg;
    qts_result_t skid_reg;
    logic        out_valid_reg;
    logic        skid_valid_reg;
    logic        sample_beat;

    assign cfg_ready    = 1'b1;
    assign sample_ready = !skid_valid_reg;
    assign sample_beat  = sample_valid && sample_ready;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            target_reg <= TGT_NONE;
        else if (cfg_valid)
            target_reg <= edit_target;
    end

    // per-sample next state
    qts_step u_step (
        .pin_a         (pin_a),
        .pin_b         (pin_b),
        .quad_pos      (quad_pos_reg),
        .dir           (dir_reg),
        .target        (target_reg),
        .values        (values_reg),
        .quad_pos_next (quad_pos_next),
        .dir_next      (dir_next),
        .moved         (moved_next),
        .values_next   (values_next)
    );

    assign result_next = '{moved: moved_next, turn_up: dir_next, values: values_next};

    // encoder and time state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_pos_reg <= 2'd0;
            dir_reg      <= 1'b1;
            values_reg   <= '0;
        end
        else if (sample_beat)
        begin
            quad_pos_reg <= quad_pos_next;
            dir_reg      <= dir_next;
            values_reg   <= values_next;
        end
    end

    // result register and skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= sample_beat;
            end
        end
        else if (sample_beat)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || result_ready)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (sample_beat)
                out_reg <= result_next;
        end
        else if (sample_beat)
        begin
            skid_reg <= result_next;
        end
    end

    assign result_valid      = out_valid_reg;
    assign moved             = out_reg.moved;
    assign turn_up           = out_reg.turn_up;
    assign day_value         = out_reg.values.day;
    assign hour_tens         = out_reg.values.hour.tens;
    assign hour_ones         = out_reg.values.hour.ones;
    assign minute_tens       = out_reg.values.minute.tens;
    assign minute_ones       = out_reg.values.minute.ones;
    assign alarm_hour_tens   = out_reg.values.alarm_hour.tens;
    assign alarm_hour_ones   = out_reg.values.alarm_hour.ones;
    assign alarm_minute_tens = out_reg.values.alarm_minute.tens;
    assign alarm_minute_ones = out_reg.values.alarm_minute.ones;

`ifndef SYNTHESIS
    // skid entry only fills behind a held result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without result register");

    // a held result is never dropped
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    // a sample beat always leaves a result valid next cycle
    a_sample_yields: assert property (@(posedge clk) disable iff (!rst_n)
        sample_beat |=> result_valid)
        else $error("sample beat produced no result");

    // day, hour tens, minute digits and alarm minute tens stay within their ranges
    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        values_reg.day <= DAY_LAST && values_reg.hour.tens <= HOUR_TENS_LAST &&
        values_reg.minute.tens <= MIN_TENS_LAST && values_reg.minute.ones <= ONES_LAST &&
        values_reg.alarm_minute.tens <= MIN_TENS_LAST)
        else $error("time value out of range");
`endif

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives encoder pin samples into the quadrature time setter and checks every
// readout beat against a local model of the decode and BCD stepping, across
// all edit target settings, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

    import qts_pkg::*;

    // edit target codes outside the named set
    localparam logic [2:0] TGT_RSVD6 = 3'd6;
    localparam logic [2:0] TGT_RSVD7 = 3'd7;

    // encoder positions, b in bit 1 and a in bit 0
    localparam logic [1:0] POS_LOW  = 2'd0;
    localparam logic [1:0] POS_A    = 2'd1;
    localparam logic [1:0] POS_B    = 2'd2;
    localparam logic [1:0] POS_BOTH = 2'd3;

    localparam int PHASE_ITEMS  = 163;
    localparam int HOLD_AT      = 600;
    localparam int HOLD_LEN     = 80;
    localparam int STALL_LIMIT  = 1000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic a;
        logic b;
    } pin_sample_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] edit_target;
    logic       sample_valid = 1'b0;
    logic       sample_ready;
    logic       pin_a = 1'b0;
    logic       pin_b = 1'b0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    logic       moved;
    logic       turn_up;
    logic [2:0] day_value;
    logic [1:0] hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
    logic [1:0] alarm_hour_tens;
    logic [3:0] alarm_hour_ones;
    logic [2:0] alarm_minute_tens;
    logic [3:0] alarm_minute_ones;

    // pending samples and predicted readouts
    pin_sample_t encoder_samples[$];
    qts_result_t predicted_readouts[$];

    // local copy of the setter state
    logic [2:0]  target_copy = TGT_NONE;
    logic [1:0]  quad_pos    = POS_LOW;
    logic        turn_cw     = 1'b1;
    qts_time_t   setting     = '0;

    // generator view of the encoder position
    logic [1:0]  gen_pos = POS_LOW;

    // run bookkeeping
    int          samples_accepted = 0;
    int          readouts_checked = 0;
    int          moves_seen       = 0;
    int          target_writes    = 0;
    int          mismatch_count   = 0;
    int          idle_cycles      = 0;
    logic        sample_taken     = 1'b0;
    logic        any_beat;
    qts_result_t seen_readout;
    qts_result_t want_readout;

    // sender and receiver pacing
    pin_sample_t next_sample;
    int          burst_left = 1;
    int          gap_left   = 0;
    int          hold_left  = 0;
    logic        hold_done  = 1'b0;
    int          stall_mode = 0;
    int          mode_left  = 0;
    int          stall_tick = 0;

    quadrature_time_setter u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .edit_target       (edit_target),
        .sample_valid      (sample_valid),
        .sample_ready      (sample_ready),
        .pin_a             (pin_a),
        .pin_b             (pin_b),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .moved             (moved),
        .turn_up           (turn_up),
        .day_value         (day_value),
        .hour_tens         (hour_tens),
        .hour_ones         (hour_ones),
        .minute_tens       (minute_tens),
        .minute_ones       (minute_ones),
        .alarm_hour_tens   (alarm_hour_tens),
        .alarm_hour_ones   (alarm_hour_ones),
        .alarm_minute_tens (alarm_minute_tens),
        .alarm_minute_ones (alarm_minute_ones)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // quadrature decode: returns {direction, next position}
    function automatic logic [2:0] quad_decode(input logic [1:0] pos, input logic a,
                                               input logic b, input logic dir_in);
        logic [1:0] nxt;
        logic       dir;
        nxt = pos;
        dir = dir_in;
        case (pos)
            POS_LOW:
            begin
                if (a) begin nxt = POS_A; dir = 1'b1; end
                else if (b) begin nxt = POS_B; dir = 1'b0; end
            end
            POS_A:
            begin
                if (!a) begin nxt = POS_LOW; dir = 1'b0; end
                else if (b) begin nxt = POS_BOTH; dir = 1'b1; end
            end
            POS_B:
            begin
                if (a) begin nxt = POS_BOTH; dir = 1'b0; end
                else if (!b) begin nxt = POS_LOW; dir = 1'b1; end
            end
            default:
            begin
                if (!a) begin nxt = POS_B; dir = 1'b1; end
                else if (!b) begin nxt = POS_A; dir = 1'b0; end
            end
        endcase
        return {dir, nxt};
    endfunction

    // one detent step along the gray sequence
    function automatic logic [1:0] rotated(input logic [1:0] pos, input logic cw);
        case (pos)
            POS_LOW: return cw ? POS_A : POS_B;
            POS_A:   return cw ? POS_BOTH : POS_LOW;
            POS_B:   return cw ? POS_LOW : POS_BOTH;
            default: return cw ? POS_B : POS_A;
        endcase
    endfunction

    // bcd hour step with wrap at 23
    function automatic qts_hour_t hour_stepped(input qts_hour_t h, input logic up);
        qts_hour_t r;
        r = h;
        if (up)
        begin
            if (h.tens >= HOUR_TENS_LAST && h.ones >= HOUR_ONES_LAST)
                r = '0;
            else if (h.ones >= ONES_LAST)
            begin
                r.tens = h.tens + 2'd1;
                r.ones = 4'd0;
            end
            else
                r.ones = h.ones + 4'd1;
        end
        else if (h.ones == 4'd0)
        begin
            if (h.tens == 2'd0)
            begin
                r.tens = HOUR_TENS_LAST;
                r.ones = HOUR_ONES_LAST;
            end
            else
            begin
                r.tens = h.tens - 2'd1;
                r.ones = ONES_LAST;
            end
        end
        else
            r.ones = h.ones - 4'd1;
        return r;
    endfunction

    // bcd minute step with wrap at 59
    function automatic qts_minute_t minute_stepped(input qts_minute_t m, input logic up);
        qts_minute_t r;
        r = m;
        if (up)
        begin
            if (m.ones >= ONES_LAST)
            begin
                r.ones = 4'd0;
                r.tens = (m.tens >= MIN_TENS_LAST) ? 3'd0 : m.tens + 3'd1;
            end
            else
                r.ones = m.ones + 4'd1;
        end
        else if (m.ones == 4'd0)
        begin
            r.tens = (m.tens == 3'd0) ? MIN_TENS_LAST : m.tens - 3'd1;
            r.ones = ONES_LAST;
        end
        else
            r.ones = m.ones - 4'd1;
        return r;
    endfunction

    // advance the local setter copy by one accepted sample
    function automatic void apply_encoder_sample(input logic a, input logic b);
        logic [2:0]  decoded;
        logic        moved_now;
        qts_result_t r;
        decoded   = quad_decode(quad_pos, a, b, turn_cw);
        moved_now = (decoded[1:0] != quad_pos);
        quad_pos  = decoded[1:0];
        turn_cw   = decoded[2];
        if (moved_now)
        begin
            moves_seen++;
            case (target_copy)
                TGT_DAY:
                    setting.day = turn_cw ? ((setting.day >= DAY_LAST) ? 3'd0 : setting.day + 3'd1)
                                          : ((setting.day == 3'd0) ? DAY_LAST : setting.day - 3'd1);
                TGT_HOUR:         setting.hour = hour_stepped(setting.hour, turn_cw);
                TGT_MINUTE:       setting.minute = minute_stepped(setting.minute, turn_cw);
                TGT_ALARM_HOUR:   setting.alarm_hour = hour_stepped(setting.alarm_hour, turn_cw);
                TGT_ALARM_MINUTE:
                    setting.alarm_minute = minute_stepped(setting.alarm_minute, turn_cw);
                default:          ;
            endcase
        end
        r.moved   = moved_now;
        r.turn_up = turn_cw;
        r.values  = setting;
        predicted_readouts.push_back(r);
    endfunction

    function automatic string readout_text(input qts_result_t r);
        return $sformatf("moved=%0d up=%0d day=%0d time=%0d%0d:%0d%0d alarm=%0d%0d:%0d%0d",
                         r.moved, r.turn_up, r.values.day,
                         r.values.hour.tens, r.values.hour.ones,
                         r.values.minute.tens, r.values.minute.ones,
                         r.values.alarm_hour.tens, r.values.alarm_hour.ones,
                         r.values.alarm_minute.tens, r.values.alarm_minute.ones);
    endfunction

    // queue one sample and follow the position it leads to
    task automatic queue_sample(input logic a, input logic b);
        logic [2:0] decoded;
        encoder_samples.push_back('{a: a, b: b});
        decoded = quad_decode(gen_pos, a, b, 1'b1);
        gen_pos = decoded[1:0];
    endtask

    // mostly clean rotations, some dwell and some pin noise
    task automatic queue_random_phase(input int count);
        int stop_at;
        int kind;
        int len;
        logic cw;
        logic [1:0] np;
        stop_at = encoder_samples.size() + count;
        while (encoder_samples.size() < stop_at)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                cw  = 1'($urandom_range(0, 1));
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 75) : $urandom_range(1, 12);
                repeat (len)
                begin
                    if ($urandom_range(0, 5) == 0)
                        queue_sample(gen_pos[0], gen_pos[1]);
                    np = rotated(gen_pos, cw);
                    queue_sample(np[0], np[1]);
                end
            end
            else if (kind == 7)
            begin
                repeat ($urandom_range(1, 5))
                    queue_sample(gen_pos[0], gen_pos[1]);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    queue_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // wait until the block has drained every sample and readout
    task automatic wait_quiet();
        do @(posedge clk);
        while (encoder_samples.size() != 0 || sample_valid || predicted_readouts.size() != 0);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_edit_target(input logic [2:0] code);
        @(negedge clk);
        cfg_valid   <= 1'b1;
        edit_target <= code;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // sample driver: bursts with random gaps
    always @(negedge clk)
    begin
        if (rst_n && !(sample_valid && !sample_taken))
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                sample_valid <= 1'b0;
            end
            else if (encoder_samples.size() != 0)
            begin
                next_sample = encoder_samples.pop_front();
                sample_valid <= 1'b1;
                pin_a        <= next_sample.a;
                pin_b        <= next_sample.b;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                sample_valid <= 1'b0;
        end
    end

    // readout receiver: one long hold-off, otherwise changing stall modes
    always @(negedge clk)
    begin
        stall_tick++;
        if (hold_left != 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else if (!hold_done && samples_accepted >= HOLD_AT)
        begin
            hold_left = HOLD_LEN;
            hold_done = 1'b1;
            result_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(8, 60);
            end
            else
                mode_left--;
            case (stall_mode)
                0:       result_ready <= 1'b1;
                1:       result_ready <= 1'($urandom_range(0, 1));
                2:       result_ready <= ($urandom_range(0, 3) == 0);
                default: result_ready <= (stall_tick % 5 != 4);
            endcase
        end
    end

    // monitor: predict on sample beats, check readout beats
    always @(posedge clk)
    begin
        sample_taken <= sample_valid && sample_ready;
        if (rst_n)
        begin
            any_beat = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                target_copy = edit_target;
                target_writes++;
                any_beat = 1'b1;
            end
            if (sample_valid && sample_ready)
            begin
                apply_encoder_sample(pin_a, pin_b);
                samples_accepted++;
                any_beat = 1'b1;
            end
            if (result_valid && result_ready)
            begin
                any_beat = 1'b1;
                seen_readout = {moved, turn_up, day_value, hour_tens, hour_ones,
                                minute_tens, minute_ones, alarm_hour_tens, alarm_hour_ones,
                                alarm_minute_tens, alarm_minute_ones};
                if (predicted_readouts.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected readout: %s", readout_text(seen_readout));
                end
                else
                begin
                    want_readout = predicted_readouts.pop_front();
                    if (seen_readout !== want_readout)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("readout %0d mismatch\n  expected %s\n  actual   %s",
                                     readouts_checked, readout_text(want_readout),
                                     readout_text(seen_readout));
                    end
                end
                readouts_checked++;
            end
            idle_cycles = any_beat ? 0 : idle_cycles + 1;
        end
    end

    // watchdog on cycles without any beat
    initial
    begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("testbench NOT OK");
        $finish;
    end

    // stimulus and end of run
    initial
    begin : stimulus
        logic [2:0] phase_targets [0:7];
        int p;
        phase_targets = '{TGT_HOUR, TGT_MINUTE, TGT_DAY, TGT_ALARM_HOUR,
                          TGT_ALARM_MINUTE, TGT_RSVD6, TGT_NONE, TGT_RSVD7};
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        edit_target = TGT_NONE;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // no target: still sample, then each both-pins-flip case
        queue_sample(1'b0, 1'b0);
        queue_sample(1'b1, 1'b1);
        queue_sample(1'b0, 1'b0);
        queue_sample(1'b0, 1'b1);
        queue_sample(1'b1, 1'b0);
        queue_sample(1'b0, 1'b0);
        queue_sample(1'b0, 1'b1);
        wait_quiet();

        // hour: down through 00 to 23, then back up through 23 to 00
        write_edit_target(TGT_HOUR);
        queue_sample(1'b1, 1'b1);
        queue_sample(1'b1, 1'b0);
        queue_sample(1'b1, 1'b1);
        queue_sample(1'b0, 1'b1);
        wait_quiet();

        // minute, day and alarm fields: one step down past zero and one back up
        write_edit_target(TGT_MINUTE);
        queue_sample(1'b1, 1'b1);
        queue_sample(1'b0, 1'b1);
        wait_quiet();
        write_edit_target(TGT_DAY);
        queue_sample(1'b1, 1'b1);
        queue_sample(1'b0, 1'b1);
        wait_quiet();
        write_edit_target(TGT_ALARM_HOUR);
        queue_sample(1'b1, 1'b1);
        queue_sample(1'b0, 1'b1);
        wait_quiet();
        write_edit_target(TGT_ALARM_MINUTE);
        queue_sample(1'b1, 1'b1);
        queue_sample(1'b0, 1'b1);
        wait_quiet();
        write_edit_target(TGT_RSVD7);
        queue_sample(1'b1, 1'b1);

        // random phases over every target code
        for (p = 0; p < 10; p++)
        begin
            wait_quiet();
            write_edit_target((p < 8) ? phase_targets[p] : 3'($urandom_range(0, 7)));
            queue_random_phase(PHASE_ITEMS);
        end

        wait_quiet();
        repeat (4) @(posedge clk);
        if (predicted_readouts.size() != 0)
        begin
            mismatch_count += predicted_readouts.size();
            $display("%0d readouts never arrived", predicted_readouts.size());
        end

        $display("%0d samples checked as %0d readouts, %0d encoder moves, %0d target writes",
                 samples_accepted, readouts_checked, moves_seen, target_writes);
        $display("receiver hold-off of %0d cycles %0s, %0d failures",
                 HOLD_LEN, hold_done ? "done" : "missed", mismatch_count);
        if (mismatch_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
